// ----- rtl/spq_pkg.sv -----
// package: types, codes and sizes for the sorted priority queue
`default_nettype none
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic                    command;
		logic signed [VAL_W-1:0] value;
	} spq_req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [CNT_W-1:0]        count;
		logic signed [VAL_W-1:0] smallest;
		logic                    smallest_valid;
	} spq_rsp_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} spq_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_priority_queue_top.sv -----
// top level: sorted priority queue built from a chain of compare-and-shift cells
//
//  channel  | ports                 | handshake
//  request  | start, busy, req      | accepted when start && !busy
//  response | done, rsp             | one-cycle strobe, no back pressure
//
// each word is registered on accept; then every cell updates at once and
// the response is registered, with busy high until that update.
// done is high in the cycle after the update; a new word may start then.
// reset clears the count and control; cell contents stay undefined.
`default_nettype none
module sorted_priority_queue_top import spq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire spq_req_t req,
	output logic          done,
	output spq_rsp_t      rsp
);

	logic                    pending_q;
	logic                    cmd_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CNT_W-1:0]        count_q;
	logic                    done_q;
	spq_rsp_t                rsp_q;

	logic [CAPACITY-1:0]     lt;
	logic [CAPACITY-1:0]     eq;
	logic signed [VAL_W-1:0] entry   [CAPACITY];
	logic signed [VAL_W-1:0] entry_d [CAPACITY];

	logic                    full;
	logic                    found;
	spq_ctrl_t               ctrl;
	logic [CNT_W-1:0]        count_d;
	logic [1:0]              status_d;

	assign busy  = pending_q;
	assign done  = done_q;
	assign rsp   = rsp_q;
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign found = |eq;

	always_comb begin
		ctrl.ins = pending_q && (cmd_q == CMD_INSERT) && !full;
		ctrl.rem = pending_q && (cmd_q == CMD_REMOVE) && found;
		count_d  = count_q;
		status_d = ST_DONE;
		if (cmd_q == CMD_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else begin
			if (!found) begin
				status_d = ST_MISS;
			end else begin
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    lt_prev;
		logic signed [VAL_W-1:0] entry_prev;
		logic signed [VAL_W-1:0] entry_next;

		if (i == 0) begin : g_first
			assign lt_prev    = 1'b0;
			assign entry_prev = value_q;
		end else begin : g_mid
			assign lt_prev    = lt[i-1];
			assign entry_prev = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign entry_next = entry[i];
		end else begin : g_inner
			assign entry_next = entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.value      (value_q),
			.occupied   (CNT_W'(i) < count_q),
			.lt_prev    (lt_prev),
			.entry_prev (entry_prev),
			.entry_next (entry_next),
			.lt         (lt[i]),
			.eq         (eq[i]),
			.entry      (entry[i]),
			.entry_d    (entry_d[i])
		);
	end

	always_ff @(posedge clk) begin
		if (start && !pending_q) begin
			cmd_q   <= req.command;
			value_q <= req.value;
		end
		if (pending_q) begin
			rsp_q.status         <= status_d;
			rsp_q.count          <= count_d;
			rsp_q.smallest       <= (count_d != '0) ? entry_d[0] : '0;
			rsp_q.smallest_valid <= (count_d != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
		end else begin
			done_q <= pending_q;
			if (pending_q) begin
				pending_q <= 1'b0;
				count_q   <= count_d;
			end else if (start) begin
				pending_q <= 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |=> done_q && !pending_q)
		else $error("response missing after word");

	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rsp_q.smallest_valid == (rsp_q.count != '0)))
		else $error("smallest_valid disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status == ST_FULL |-> rsp_q.count == CNT_W'(CAPACITY))
		else $error("full status with room left");

endmodule
`default_nettype wire

// ----- rtl/spq_cell.sv -----
// one storage cell of the sorted chain: compare against the word and shift
`default_nettype none
module spq_cell import spq_pkg::*; (
	input  wire logic                    clk,
	input  wire spq_ctrl_t               ctrl,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire logic                    occupied,
	input  wire logic                    lt_prev,
	input  wire logic signed [VAL_W-1:0] entry_prev,
	input  wire logic signed [VAL_W-1:0] entry_next,
	output logic                         lt,
	output logic                         eq,
	output logic signed [VAL_W-1:0]      entry,
	output logic signed [VAL_W-1:0]      entry_d
);

	logic signed [VAL_W-1:0] entry_q;

	assign lt    = occupied && (entry_q < value);
	assign eq    = occupied && (entry_q == value);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctrl.ins && !lt) begin
			entry_d = lt_prev ? value : entry_prev;
		end else if (ctrl.rem && !lt) begin
			entry_d = entry_next;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
`default_nettype wire

// ----- test/sorted_priority_queue_checker.sv -----
// checker: predicts the sorted store and compares every response word with it
module sorted_priority_queue_checker import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  spq_req_t req,
	input  logic     done,
	input  spq_rsp_t rsp,
	output int       errors,
	output int       outstanding,
	output int       checked,
	output int       full_seen,
	output int       miss_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VAL_W-1:0] sorted_store[$];
	spq_rsp_t                expected_rsp[$];
	spq_rsp_t                want;
	int                      fail_cnt = 0;
	int                      pend_cnt = 0;
	int                      chk_cnt = 0;
	int                      full_cnt = 0;
	int                      miss_cnt = 0;

	assign errors      = fail_cnt;
	assign outstanding = pend_cnt;
	assign checked     = chk_cnt;
	assign full_seen   = full_cnt;
	assign miss_seen   = miss_cnt;

	function automatic spq_rsp_t update_store(spq_req_t w);
		spq_rsp_t r;
		int       pos;
		r   = '0;
		pos = 0;
		if (w.command == CMD_INSERT) begin
			if (sorted_store.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				while (pos < sorted_store.size() && sorted_store[pos] < w.value)
					pos++;
				sorted_store.insert(pos, w.value);
				r.status = ST_DONE;
			end
		end else begin
			while (pos < sorted_store.size() && sorted_store[pos] != w.value)
				pos++;
			if (pos >= sorted_store.size()) begin
				r.status = ST_MISS;
			end else begin
				sorted_store.delete(pos);
				r.status = ST_DONE;
			end
		end
		r.count = CNT_W'(sorted_store.size());
		if (sorted_store.size() > 0) begin
			r.smallest       = sorted_store[0];
			r.smallest_valid = 1'b1;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					fail_cnt++;
					$display("%0t: response with no word outstanding, expected none, actual %p",
						$time, rsp);
				end else begin
					want = expected_rsp.pop_front();
					pend_cnt--;
					chk_cnt++;
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("count", 32'(want.count), 32'(rsp.count));
					check_field("smallest", want.smallest, rsp.smallest);
					check_field("smallest_valid", 32'(want.smallest_valid),
						32'(rsp.smallest_valid));
				end
			end
			if (start && !busy) begin
				want = update_store(req);
				if (want.status == ST_FULL)
					full_cnt++;
				if (want.status == ST_MISS)
					miss_cnt++;
				expected_rsp.push_back(want);
				pend_cnt++;
			end
		end
	end

endmodule

// ----- test/testbench.sv -----
// testbench top: clock, reset, insert and remove stimulus, and the verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import spq_pkg::*;

	localparam logic signed [VAL_W-1:0] VMAX = 32'h7fff_ffff;
	localparam logic signed [VAL_W-1:0] VMIN = 32'h8000_0000;
	localparam int NUM_WORDS = 850;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	spq_req_t req;
	logic     done;
	spq_rsp_t rsp;
	int       errors;
	int       outstanding;
	int       checked;
	int       full_seen;
	int       miss_seen;

	logic signed [VAL_W-1:0] pool[6];
	int sent = 0;
	int burst_left = 0;

	sorted_priority_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	sorted_priority_queue_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.full_seen   (full_seen),
		.miss_seen   (miss_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_word(logic cmd, logic signed [VAL_W-1:0] val);
		int gap;
		start <= 1'b1;
		req   <= '{command: cmd, value: val};
		do @(posedge clk); while (busy);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				start <= 1'b0;
				req   <= '{command: 1'($urandom), value: $urandom};
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 40);
		end
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? VMAX : VMIN;
			default: return pool[$urandom_range(0, 5)];
		endcase
	endfunction

	initial begin
		int phase_len;
		int ins_pct;
		bit fill;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remove from empty, extremes, equal values, full store, hit and miss
		send_word(CMD_REMOVE, 32'sd7);
		send_word(CMD_INSERT, VMAX);
		send_word(CMD_INSERT, VMIN);
		send_word(CMD_INSERT, 32'sd0);
		send_word(CMD_INSERT, 32'sd0);
		send_word(CMD_INSERT, -32'sd1);
		send_word(CMD_INSERT, 32'sd1);
		for (int i = 0; i < 10; i++)
			send_word(CMD_INSERT, 32'(i * 7 - 30));
		send_word(CMD_INSERT, 32'sd42);
		send_word(CMD_REMOVE, 32'sd0);
		send_word(CMD_REMOVE, 32'sd12345);
		send_word(CMD_REMOVE, VMIN);
		send_word(CMD_REMOVE, VMAX);

		fill = 1'b1;
		while (sent < NUM_WORDS) begin
			phase_len = $urandom_range(24, 64);
			if (fill) begin
				ins_pct = 80;
				foreach (pool[i])
					pool[i] = $urandom_range(0, 1) ? $urandom : 32'(int'($urandom_range(0, 20)) - 10);
			end else begin
				ins_pct = ($urandom_range(0, 3) == 0) ? 50 : 25;
			end
			repeat (phase_len)
				send_word(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE,
					pick_value());
			fill = !fill;
		end
		start <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		$display("%0d words sent, %0d responses checked", sent, checked);
		$display("%0d inserts refused on a full store, %0d removes with no match",
			full_seen, miss_seen);
		if (errors == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d responses outstanding", outstanding);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
